@@ rtl/obrfe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obrfe_pkg
// shared constants, payload types and helpers for the overwriting byte ring
// ----------------------------------------------------------------------------
package obrfe_pkg;

  localparam int RING_ENTRIES = 64;
  localparam int PTR_W        = $clog2(RING_ENTRIES);
  localparam int CAP_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int CMD_W        = 2;
  localparam int STS_W        = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(63);

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH  = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_POP   = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_FRAME = CMD_W'(2);

  // status codes
  localparam logic [STS_W-1:0] STS_PUSHED = STS_W'(0);
  localparam logic [STS_W-1:0] STS_BYTE   = STS_W'(1);
  localparam logic [STS_W-1:0] STS_ERROR  = STS_W'(2);

  // frame characters
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
  localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
  localparam logic [BYTE_W-1:0] CH_O      = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_in;
  } obrfe_in_t;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [BYTE_W-1:0] data_out;
    logic              last;
  } obrfe_out_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [PTR_W-1:0]  addr;
    logic [BYTE_W-1:0] wdata;
  } obrfe_mem_req_t;

  function automatic logic frame_byte_ok(input logic [BYTE_W-1:0] b);
    logic digit;
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    return digit || (b == CH_DOLLAR) || (b == CH_C) || (b == CH_O) ||
           (b == CH_M) || (b == CH_MINUS) || (b == CH_COMMA) ||
           (b == CH_HASH) || (b == CH_DOT);
  endfunction

  // wrap_idx is the highest index in use
  function automatic logic [PTR_W-1:0] ring_adv(input logic [PTR_W-1:0] p,
                                                input logic [PTR_W-1:0] wrap_idx);
    return (p >= wrap_idx) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic obrfe_out_t make_out(input logic [STS_W-1:0]  status,
                                          input logic [BYTE_W-1:0] data,
                                          input logic              last);
    obrfe_out_t o;
    o.status   = status;
    o.data_out = data;
    o.last     = last;
    return o;
  endfunction

endpackage
`default_nettype wire

@@ rtl/obrfe_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obrfe_ram
// single-port byte memory, registered read
// ----------------------------------------------------------------------------
module obrfe_ram (
  input  wire logic                        clk,
  input  wire obrfe_pkg::obrfe_mem_req_t   req,
  output logic [obrfe_pkg::BYTE_W-1:0]     rdata
);
  import obrfe_pkg::*;

  logic [BYTE_W-1:0] mem [RING_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/overwriting_byte_ring_with_frame_extract_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// overwriting_byte_ring_with_frame_extract_core
// receive byte ring that drops its oldest byte when full, with pop and
// dollar-to-hash frame extraction
// ----------------------------------------------------------------------------
// results: push results and empty-ring or unused-command errors enter the result
//   register in the accept cycle; a pop reads memory, then loads its byte in ST_POP
// frame: each scanned byte passes ST_SCAN_RD and ST_SCAN_CHK, each emitted byte
//   ST_EMIT_RD and ST_EMIT_CHK; no item is taken meanwhile
// throughput: one push per cycle while results are taken and no capacity write waits
// reset: pointers cleared, capacity 63, result register empty; the byte memory
//   is not cleared (only written entries are ever read)
module overwriting_byte_ring_with_frame_extract_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // item input
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire obrfe_pkg::obrfe_in_t       in_item,
  // result output
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output obrfe_pkg::obrfe_out_t           out_item,
  // capacity register write
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [obrfe_pkg::CAP_W-1:0] cfg_data
);
  import obrfe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT_RD,
    ST_EMIT_CHK
  } state_t;

  localparam logic [PTR_W-1:0] EMIT_MAX = PTR_W'(RING_ENTRIES - 1);

  state_t            state;
  logic [CAP_W-1:0]  capacity;
  logic [PTR_W-1:0]  wp;          // write pointer
  logic [PTR_W-1:0]  rp;          // read pointer
  logic [PTR_W-1:0]  scan_ptr;    // scan position during a frame search
  logic              seen_dollar;
  logic [PTR_W-1:0]  emit_cnt;    // frame bytes already emitted

  logic [PTR_W-1:0]  wrap_idx;
  logic              out_free;
  logic              out_load;    // a result enters the result register
  logic              in_acc;
  logic              cfg_acc;
  logic              ring_empty;
  logic              emit_stop;
  logic [PTR_W-1:0]  wp_adv;
  logic [PTR_W-1:0]  rp_adv;
  logic [PTR_W-1:0]  scan_adv;

  obrfe_mem_req_t    mem_req;
  logic [BYTE_W-1:0] mem_rdata;

  obrfe_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // ring length is capacity+1, saturated to the memory depth
  always_comb begin
    if (int'(capacity) >= RING_ENTRIES - 1) begin
      wrap_idx = PTR_W'(RING_ENTRIES - 1);
    end else begin
      wrap_idx = PTR_W'(capacity);
    end
  end

  assign wp_adv   = ring_adv(wp, wrap_idx);
  assign rp_adv   = ring_adv(rp, wrap_idx);
  assign scan_adv = ring_adv(scan_ptr, wrap_idx);

  assign ring_empty = (wp == rp);
  assign emit_stop  = ring_empty || (emit_cnt == EMIT_MAX);

  // result register may be loaded when empty or being drained this cycle
  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = (state == ST_IDLE);
  // a pending register write goes first
  assign in_ready  = (state == ST_IDLE) && out_free && !cfg_valid;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // cycles in which the state machine loads a new result
  always_comb begin
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // pop and frame on a non-empty ring answer later
        out_load = in_acc && !((in_item.command == CMD_POP ||
                                in_item.command == CMD_FRAME) && !ring_empty);
      end
      ST_POP:      out_load = out_free;
      ST_SCAN_RD:  out_load = (scan_ptr == wp) && out_free;
      ST_EMIT_RD:  out_load = emit_stop && out_free;
      ST_EMIT_CHK: out_load = out_free;
      default:     out_load = 1'b0;
    endcase
  end

  // memory port: push write, pop read, scan read, emit read
  always_comb begin
    mem_req       = '0;
    mem_req.wdata = in_item.data_in;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && in_item.command == CMD_PUSH) begin
          mem_req.we   = 1'b1;
          mem_req.addr = wp;
        end else if (in_acc && in_item.command == CMD_POP && !ring_empty) begin
          mem_req.re   = 1'b1;
          mem_req.addr = rp;
        end
      end
      ST_SCAN_RD: begin
        if (scan_ptr != wp) begin
          mem_req.re   = 1'b1;
          mem_req.addr = scan_ptr;
        end
      end
      ST_EMIT_RD: begin
        if (!emit_stop) begin
          mem_req.re   = 1'b1;
          mem_req.addr = rp;
        end
      end
      default: begin
        mem_req.re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      capacity    <= CAP_RESET;
      wp          <= '0;
      rp          <= '0;
      out_valid   <= 1'b0;
      seen_dollar <= 1'b0;
      emit_cnt    <= '0;
    end else begin
      // a drained result leaves unless a new one takes its place
      if (out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cfg_acc) begin
            // a zero capacity is ignored
            if (cfg_data != '0) begin
              capacity <= cfg_data;
              wp       <= '0;
              rp       <= '0;
            end
          end else if (in_acc) begin
            case (in_item.command)
              CMD_PUSH: begin
                // full ring: drop the oldest byte
                if (wp_adv == rp) begin
                  rp <= rp_adv;
                end
                wp        <= wp_adv;
                out_valid <= 1'b1;
                out_item  <= make_out(STS_PUSHED, '0, 1'b1);
              end
              CMD_POP: begin
                if (ring_empty) begin
                  out_valid <= 1'b1;
                  out_item  <= make_out(STS_ERROR, '0, 1'b1);
                end else begin
                  state <= ST_POP;
                end
              end
              CMD_FRAME: begin
                if (ring_empty) begin
                  out_valid <= 1'b1;
                  out_item  <= make_out(STS_ERROR, '0, 1'b1);
                end else begin
                  scan_ptr    <= rp;
                  seen_dollar <= 1'b0;
                  emit_cnt    <= '0;
                  state       <= ST_SCAN_RD;
                end
              end
              default: begin
                // unused command
                out_valid <= 1'b1;
                out_item  <= make_out(STS_ERROR, '0, 1'b1);
              end
            endcase
          end
        end
        ST_POP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_item  <= make_out(STS_BYTE, mem_rdata, 1'b1);
            rp        <= rp_adv;
            state     <= ST_IDLE;
          end
        end
        ST_SCAN_RD: begin
          if (scan_ptr == wp) begin
            // no complete frame; read pointer moves made so far stay
            if (out_free) begin
              out_valid <= 1'b1;
              out_item  <= make_out(STS_ERROR, '0, 1'b1);
              state     <= ST_IDLE;
            end
          end else begin
            state <= ST_SCAN_CHK;
          end
        end
        ST_SCAN_CHK: begin
          if (mem_rdata == CH_DOLLAR) begin
            seen_dollar <= 1'b1;
            rp          <= scan_ptr;
            scan_ptr    <= scan_adv;
            state       <= ST_SCAN_RD;
          end else if (mem_rdata == CH_HASH && seen_dollar) begin
            // frame found: read pointer sits on its opening dollar
            state <= ST_EMIT_RD;
          end else begin
            scan_ptr <= scan_adv;
            state    <= ST_SCAN_RD;
          end
        end
        ST_EMIT_RD: begin
          if (emit_stop) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_item  <= make_out(STS_ERROR, '0, 1'b1);
              state     <= ST_IDLE;
            end
          end else begin
            state <= ST_EMIT_CHK;
          end
        end
        ST_EMIT_CHK: begin
          if (out_free) begin
            out_valid <= 1'b1;
            rp        <= rp_adv;
            if (!frame_byte_ok(mem_rdata)) begin
              // bad byte is consumed and ends the frame
              out_item <= make_out(STS_ERROR, '0, 1'b1);
              state    <= ST_IDLE;
            end else if (mem_rdata == CH_HASH) begin
              out_item <= make_out(STS_BYTE, mem_rdata, 1'b1);
              state    <= ST_IDLE;
            end else begin
              out_item <= make_out(STS_BYTE, mem_rdata, 1'b0);
              emit_cnt <= emit_cnt + PTR_W'(1);
              state    <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // pointers never leave the ring
  assert property (@(posedge clk) disable iff (rst)
    (wp <= wrap_idx) && (rp <= wrap_idx))
    else $error("ring pointer beyond ring length");

  // a push always leaves the ring non-empty
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_item.command == CMD_PUSH) |=> (wp != rp))
    else $error("ring empty after push");

  // capacity is never zero
  assert property (@(posedge clk) disable iff (rst)
    capacity != '0)
    else $error("zero capacity");

  // result register is never overwritten while it still holds a result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_item))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

@@ tb/sv/tb_overwriting_byte_ring_with_frame_extract_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_overwriting_byte_ring_with_frame_extract_core
// self-checking bench for the overwriting byte ring: a directed stimulus table,
// then random push/pop/frame traffic over several capacities, every result
// checked in order against a typed-in result or a cycle-free model of the ring
// ----------------------------------------------------------------------------
module tb_overwriting_byte_ring_with_frame_extract_core;
  import obrfe_pkg::*;

  // unused command code, answered with an error
  localparam logic [CMD_W-1:0] CMD_SPARE = CMD_W'(3);

  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 4;     // quiet cycles before a capacity write
  localparam int END_CYCLES     = 16;    // quiet cycles before the verdict
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
  localparam int PHASE_ITEMS    = 64;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_RARE_STALL, RDY_EVERY_THIRD} rx_mode_t;

  typedef struct {
    obrfe_in_t  item;
    bit         fixed;  // expected result typed in below
    obrfe_out_t res;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  obrfe_in_t  in_item;
  logic       out_valid;
  logic       out_ready;
  obrfe_out_t out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  // model of the ring
  logic [BYTE_W-1:0] mdl_store [RING_ENTRIES];
  int mdl_wr;
  int mdl_rd;
  int mdl_cap;

  obrfe_out_t awaited_results_q[$];
  stim_row_t  stim_rows[$];

  int mismatch_count = 0;
  int idle_cycles    = 0;
  int items_sent     = 0;
  int burst_left     = 0;
  bit hold_request   = 1'b0;
  obrfe_out_t want;

  overwriting_byte_ring_with_frame_extract_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic obrfe_out_t result_of(input logic [STS_W-1:0] sts,
                                           input logic [BYTE_W-1:0] d,
                                           input logic l);
    obrfe_out_t r;
    r.status   = sts;
    r.data_out = d;
    r.last     = l;
    return r;
  endfunction

  // ring length is capacity plus one, saturated to the store size
  function automatic int ring_next(input int p);
    int len;
    len = (mdl_cap + 1 > RING_ENTRIES) ? RING_ENTRIES : mdl_cap + 1;
    return (p + 1 >= len) ? 0 : p + 1;
  endfunction

  function automatic bit is_frame_char(input logic [BYTE_W-1:0] b);
    case (b)
      CH_DOLLAR, CH_HASH, CH_C, CH_O, CH_M, CH_MINUS, CH_COMMA, CH_DOT: return 1'b1;
      default: return (b >= CH_ZERO) && (b <= CH_NINE);
    endcase
  endfunction

  task automatic apply_capacity(input logic [CAP_W-1:0] v);
    // a zero write leaves capacity and pointers alone
    if (v != '0) begin
      mdl_cap = int'(v);
      mdl_wr  = 0;
      mdl_rd  = 0;
    end
  endtask

  // works out every result caused by one accepted item
  task automatic ring_model_step(input obrfe_in_t it);
    int t;
    int n;
    bit seen_dollar;
    bit found;
    bit done;
    logic [BYTE_W-1:0] b;
    if (it.command == CMD_PUSH) begin
      // full ring: the oldest byte goes first
      if (ring_next(mdl_wr) == mdl_rd) mdl_rd = ring_next(mdl_rd);
      mdl_store[PTR_W'(mdl_wr)] = it.data_in;
      mdl_wr = ring_next(mdl_wr);
      awaited_results_q.push_back(result_of(STS_PUSHED, '0, 1'b1));
    end else if (it.command == CMD_POP) begin
      if (mdl_wr == mdl_rd) begin
        awaited_results_q.push_back(result_of(STS_ERROR, '0, 1'b1));
      end else begin
        awaited_results_q.push_back(result_of(STS_BYTE, mdl_store[PTR_W'(mdl_rd)], 1'b1));
        mdl_rd = ring_next(mdl_rd);
      end
    end else if (it.command != CMD_FRAME || mdl_wr == mdl_rd) begin
      awaited_results_q.push_back(result_of(STS_ERROR, '0, 1'b1));
    end else begin
      // scan: each dollar pulls the read pointer up, a hash after one ends it
      t = mdl_rd;
      seen_dollar = 1'b0;
      found = 1'b0;
      done = 1'b0;
      while (!done) begin
        if (t == mdl_wr) begin
          awaited_results_q.push_back(result_of(STS_ERROR, '0, 1'b1));
          done = 1'b1;
        end else begin
          b = mdl_store[PTR_W'(t)];
          if (b == CH_DOLLAR) begin
            seen_dollar = 1'b1;
            mdl_rd = t;
          end else if (b == CH_HASH && seen_dollar) begin
            found = 1'b1;
            done = 1'b1;
          end
          t = ring_next(t);
        end
      end
      // emit: pop frame bytes, a bad byte is popped and ends it with an error
      n = 0;
      done = !found;
      while (!done) begin
        if (mdl_wr == mdl_rd || n >= RING_ENTRIES - 1) begin
          awaited_results_q.push_back(result_of(STS_ERROR, '0, 1'b1));
          done = 1'b1;
        end else begin
          b = mdl_store[PTR_W'(mdl_rd)];
          mdl_rd = ring_next(mdl_rd);
          if (!is_frame_char(b)) begin
            awaited_results_q.push_back(result_of(STS_ERROR, '0, 1'b1));
            done = 1'b1;
          end else if (b == CH_HASH) begin
            awaited_results_q.push_back(result_of(STS_BYTE, b, 1'b1));
            done = 1'b1;
          end else begin
            awaited_results_q.push_back(result_of(STS_BYTE, b, 1'b0));
            n++;
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    mismatch_count++;
    $display("MISMATCH at %0t: %s got %0h want %0h", $time, what, got, exp_v);
  endtask

  // results are compared at the rising edge, in order of arrival
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (out_valid && out_ready) begin
        if (awaited_results_q.size() == 0) begin
          report_mismatch("result with nothing awaited", 32'(out_item), '0);
        end else begin
          want = awaited_results_q.pop_front();
          if (out_item.status !== want.status)
            report_mismatch("status", 32'(out_item.status), 32'(want.status));
          if (out_item.data_out !== want.data_out)
            report_mismatch("data_out", 32'(out_item.data_out), 32'(want.data_out));
          if (out_item.last !== want.last)
            report_mismatch("last", 32'(out_item.last), 32'(want.last));
        end
      end
    end
  end

  // watchdog: ends a run that has stopped moving
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // stall pattern of its own, with one long hold-off on request
  initial begin
    rx_mode_t stall_mode;
    int mode_left;
    int beat;
    stall_mode = RDY_ALWAYS;
    mode_left = 0;
    beat = 0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          stall_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        beat++;
        case (stall_mode)
          RDY_ALWAYS:     out_ready <= 1'b1;
          RDY_COIN:       out_ready <= 1'($urandom_range(0, 1));
          RDY_RARE_STALL: out_ready <= ($urandom_range(0, 7) != 0);
          default:        out_ready <= (beat % 3 != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- sender

  // offers one item in bursts with gaps; valid stays high on return, so the
  // caller either offers the next item or lowers valid in the same step
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                           input bit fixed, input obrfe_out_t fixed_res);
    int gap;
    int n0;
    obrfe_in_t it;
    it.command = cmd;
    it.data_in = data;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge: its results cannot show before the next one
    n0 = awaited_results_q.size();
    ring_model_step(it);
    if (fixed) begin
      while (awaited_results_q.size() > n0) void'(awaited_results_q.pop_back());
      awaited_results_q.push_back(fixed_res);
    end
    items_sent++;
    @(negedge clk);
  endtask

  // lowers valid and waits until every awaited result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (awaited_results_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_capacity(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                         input bit fixed, input logic [STS_W-1:0] sts);
    stim_row_t r;
    r.item.command = cmd;
    r.item.data_in = data;
    r.fixed = fixed;
    r.res = result_of(sts, '0, 1'b1);
    stim_rows.push_back(r);
  endtask

  // mostly well-formed frames with random bodies, the rest pops and noise
  task automatic send_random_transaction();
    int pick;
    int body;
    int k;
    int i;
    logic [BYTE_W-1:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      repeat ($urandom_range(0, 2))
        send_item(CMD_PUSH, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
      send_item(CMD_PUSH, CH_DOLLAR, 1'b0, '0);
      // now and then a body that fills the whole ring
      body = ($urandom_range(0, 19) == 0 && mdl_cap > 2) ? mdl_cap - 2 : $urandom_range(0, 8);
      for (i = 0; i < body; i++) begin
        k = $urandom_range(0, 15);
        if ($urandom_range(0, 29) == 0) b = CH_DOLLAR;
        else if ($urandom_range(0, 39) == 0) b = CH_HASH;
        else if (k < 10) b = CH_ZERO + BYTE_W'(k);
        else begin
          case (k)
            10: b = CH_C;
            11: b = CH_O;
            12: b = CH_M;
            13: b = CH_MINUS;
            14: b = CH_COMMA;
            default: b = CH_DOT;
          endcase
        end
        send_item(CMD_PUSH, b, 1'b0, '0);
      end
      if ($urandom_range(0, 9) == 0) begin
        // byte outside the frame set
        b = BYTE_W'($urandom_range(0, 255));
        while (is_frame_char(b)) b = BYTE_W'($urandom_range(0, 255));
        send_item(CMD_PUSH, b, 1'b0, '0);
      end
      if ($urandom_range(0, 9) != 0) send_item(CMD_PUSH, CH_HASH, 1'b0, '0);
      send_item(CMD_FRAME, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
    end else if (pick < 70) begin
      repeat ($urandom_range(1, 3))
        send_item(CMD_POP, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
    end else if (pick < 80) begin
      send_item(CMD_FRAME, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
    end else if (pick < 92) begin
      send_item(CMD_PUSH, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
    end else begin
      send_item(CMD_SPARE, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------- main flow

  initial begin
    logic [CAP_W-1:0] cap_plan [8];
    int ph;
    int phase_start;
    int r;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    mdl_wr    = 0;
    mdl_rd    = 0;
    mdl_cap   = int'(CAP_RESET);

    // after reset: empty ring errors, unused command, extreme push bytes
    add_row(CMD_POP,   8'h00, 1'b1, STS_ERROR);
    add_row(CMD_FRAME, 8'h00, 1'b1, STS_ERROR);
    add_row(CMD_SPARE, 8'hFF, 1'b1, STS_ERROR);
    add_row(CMD_PUSH,  8'h00, 1'b1, STS_PUSHED);
    add_row(CMD_PUSH,  8'hFF, 1'b1, STS_PUSHED);
    add_row(CMD_POP,   8'hFF, 1'b0, STS_BYTE);
    add_row(CMD_POP,   8'h00, 1'b0, STS_BYTE);
    // stray hash ahead of the dollar, then a complete frame of every class
    add_row(CMD_PUSH,  CH_HASH,   1'b1, STS_PUSHED);
    add_row(CMD_PUSH,  CH_DOLLAR, 1'b1, STS_PUSHED);
    add_row(CMD_PUSH,  CH_C,      1'b1, STS_PUSHED);
    add_row(CMD_PUSH,  CH_O,      1'b1, STS_PUSHED);
    add_row(CMD_PUSH,  CH_M,      1'b1, STS_PUSHED);
    add_row(CMD_PUSH,  CH_MINUS,  1'b1, STS_PUSHED);
    add_row(CMD_PUSH,  CH_NINE,   1'b1, STS_PUSHED);
    add_row(CMD_PUSH,  CH_COMMA,  1'b1, STS_PUSHED);
    add_row(CMD_PUSH,  CH_DOT,    1'b1, STS_PUSHED);
    add_row(CMD_PUSH,  CH_ZERO,   1'b1, STS_PUSHED);
    add_row(CMD_PUSH,  CH_HASH,   1'b1, STS_PUSHED);
    add_row(CMD_FRAME, 8'h5A,     1'b0, STS_BYTE);
    // frame with no hash yet: scan runs into the write pointer
    add_row(CMD_PUSH,  CH_DOLLAR, 1'b1, STS_PUSHED);
    add_row(CMD_PUSH,  BYTE_W'(CH_ZERO + 5), 1'b1, STS_PUSHED);
    add_row(CMD_FRAME, 8'hA5,     1'b0, STS_ERROR);
    // bad byte inside the frame, then the leftover hash
    add_row(CMD_PUSH,  8'h61,     1'b1, STS_PUSHED);
    add_row(CMD_PUSH,  CH_HASH,   1'b1, STS_PUSHED);
    add_row(CMD_FRAME, 8'h00,     1'b0, STS_ERROR);
    add_row(CMD_POP,   8'h00,     1'b0, STS_BYTE);

    // capacity plan: smallest, largest, an ignored zero, small and random ones
    cap_plan[0] = CAP_W'(1);
    cap_plan[1] = CAP_W'(63);
    cap_plan[2] = CAP_W'(0);
    cap_plan[3] = CAP_W'(2);
    cap_plan[4] = CAP_W'(7);
    cap_plan[5] = CAP_W'($urandom_range(3, 62));
    cap_plan[6] = CAP_W'(1);
    cap_plan[7] = CAP_W'(63);

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (r = 0; r < stim_rows.size(); r++)
      send_item(stim_rows[r].item.command, stim_rows[r].item.data_in,
                stim_rows[r].fixed, stim_rows[r].res);

    for (ph = 0; ph < 8; ph++) begin
      write_capacity(cap_plan[ph]);
      if (ph == 1) begin
        // receiver holds off while pushes keep coming, so the input stalls;
        // then the sender waits for every result
        hold_request = 1'b1;
        repeat (24) send_item(CMD_PUSH, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
        wait_drained();
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_random_transaction();
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
